// ===== rtl/dhcl_pkg.sv =====
// Package with types, codes and helpers shared by the lease machine modules.
`timescale 1ns / 1ps
package dhcl_pkg;

   localparam int unsigned RETRY_LIMIT = 3;
   localparam logic [31:0] DEFAULT_LEASE = 32'd3600;
   localparam logic [31:0] RELEASED_DEADLINE = 32'h7fffffff;
   localparam logic [31:0] LEASE_MARGIN_DIV = 32'd14400;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_MESSAGE = 3'd1,
      ACT_RENEW   = 3'd2,
      ACT_LINK    = 3'd3,
      ACT_FOREIGN = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      PH_INIT       = 3'd0,
      PH_REQUESTING = 3'd1,
      PH_BOUND      = 3'd2,
      PH_RENEWING   = 3'd3,
      PH_REBINDING  = 3'd4,
      PH_RENEW_REQ  = 3'd5,
      PH_RELEASED   = 3'd6
   } phase_type;

   localparam logic [1:0] LS_NONE = 2'd0;
   localparam logic [1:0] LS_KERNEL = 2'd1;
   localparam logic [1:0] LS_RAW = 2'd2;

   localparam logic [7:0] MT_OFFER = 8'd2;
   localparam logic [7:0] MT_ACK = 8'd5;
   localparam logic [7:0] MT_NAK = 8'd6;

   localparam logic [2:0] SK_NONE = 3'd0;
   localparam logic [2:0] SK_DISCOVER = 3'd1;
   localparam logic [2:0] SK_SELECT = 3'd2;
   localparam logic [2:0] SK_RENEW = 3'd3;
   localparam logic [2:0] SK_REBIND = 3'd4;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_DECONFIG = 3'd1;
   localparam logic [2:0] EV_BOUND = 3'd2;
   localparam logic [2:0] EV_RENEWED = 3'd3;
   localparam logic [2:0] EV_NAK = 3'd4;
   localparam logic [2:0] EV_NAK_DECONFIG = 3'd5;

   localparam logic [2:0] CSR_REQ_ADDR = 3'd0;
   localparam logic [2:0] CSR_LEASE_CAP = 3'd1;
   localparam logic [2:0] CSR_AGG_WINDOW = 3'd2;
   localparam logic [2:0] CSR_AGG_RETRY = 3'd3;
   localparam logic [2:0] CSR_NORM_RETRY = 3'd4;
   localparam logic [2:0] CSR_FALLBACK = 3'd5;

   localparam int unsigned REQ_BITS = 3 + 32 + 8 + 32 + 1 + 32 + 32 + 1 + 32 + 32 + 32;
   localparam int unsigned REQ_DATA_W = 240;
   localparam int unsigned RSP_BITS = 3 + 32 + 32 + 32 + 3 + 3 + 2 + 32 + 31 + 1;
   localparam int unsigned RSP_DATA_W = 176;

   typedef struct packed {
      logic [31:0] fresh_xid;
      logic [31:0] foreign_requested_address;
      logic [31:0] lease_seconds_in;
      logic        lease_valid;
      logic [31:0] offered_address;
      logic [31:0] sid_value;
      logic        sid_valid;
      logic [31:0] message_xid;
      logic [7:0]  message_type;
      logic [31:0] now_seconds;
      logic [2:0]  action;
   } req_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      req_type     req;
      logic [30:0] lease_clamped;
   } work_type;

   typedef struct packed {
      logic        zeroconf_hint;
      logic [30:0] lease_out;
      logic [31:0] next_timeout;
      logic [1:0]  listen_kind;
      logic [2:0]  client_state;
      logic [2:0]  script_event;
      logic [31:0] address_out;
      logic [31:0] server_out;
      logic [31:0] xid_out;
      logic [2:0]  send_kind;
   } rsp_type;

   typedef struct packed {
      logic [31:0] req_addr;
      logic [30:0] lease_cap;
      logic [15:0] agg_window;
      logic [15:0] agg_retry;
      logic [15:0] norm_retry;
      logic [15:0] fallback;
   } csr_type;

   function automatic logic [31:0] retry_delay(input logic [1:0] n);
      logic [31:0] d;
      begin
         case (n)
            2'd0: d = 32'd2;
            2'd1: d = 32'd4;
            default: d = 32'd10;
         endcase
         retry_delay = d;
      end
   endfunction

endpackage

// ===== rtl/dhcl_front.sv =====
// Front end: accepts items and clamps the lease of each item.
`timescale 1ns / 1ps
module dhcl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dhcl_pkg::req_type  in_req,
   input  logic [30:0]        lease_cap,
   output logic               out_valid,
   input  logic               out_ready,
   output dhcl_pkg::work_type out_work
);
   logic               valid_ff, valid_in;
   dhcl_pkg::work_type work_ff, work_in;
   logic [31:0]        lease_raw;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work = work_ff;

   always_comb begin
      lease_raw = in_req.lease_valid ? in_req.lease_seconds_in : dhcl_pkg::DEFAULT_LEASE;
      work_in.req = in_req;
      work_in.lease_clamped = (lease_raw > {1'b0, lease_cap}) ? lease_cap : lease_raw[30:0];
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end
endmodule

// ===== rtl/dhcl_back.sv =====
// Back end: lease state machine that updates state and builds one result per item.
`timescale 1ns / 1ps
module dhcl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dhcl_pkg::work_type in_work,
   input  dhcl_pkg::csr_type  csr,
   output logic               out_valid,
   input  logic               out_ready,
   output dhcl_pkg::rsp_type  out_rsp
);
   dhcl_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  retry_ff, retry_in, listen_ff, listen_in;
   logic [31:0] xid_ff, xid_in, server_ff, server_in, wanted_ff, wanted_in;
   logic [31:0] deadline_ff, deadline_in, renew_ff, renew_in, rebind_ff, rebind_in;
   logic [30:0] lease_ff, lease_in;
   logic [31:0] start_ff, start_in, agg_end_ff, agg_end_in, fb_ff, fb_in;
   logic        started_ff, started_in;
   logic [31:0] margin_ff, margin_in;
   logic        rvalid_ff, rvalid_in;
   dhcl_pkg::rsp_type rsp_ff, rsp_in;

   logic        take;
   logic [31:0] now, gap, margin, pause;
   logic [2:0]  send, script;
   logic [31:0] srv;
   logic        hint, do_renew;
   logic [34:0] l7;
   logic [63:0] mprod;

   assign in_ready = !rvalid_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = rvalid_ff;
   assign out_rsp = rsp_ff;
   assign now = in_work.req.now_seconds;

   // lease / 14400 + 1 from the stored lease, by reciprocal multiply, registered.
   always_comb begin
      mprod = {33'd0, lease_in} * 64'd2443359173;
      margin_in = {13'd0, mprod[63:45]} + 32'd1;
   end

   always_comb begin
      phase_in = phase_ff; retry_in = retry_ff; listen_in = listen_ff;
      xid_in = xid_ff; server_in = server_ff; wanted_in = wanted_ff;
      deadline_in = deadline_ff; renew_in = renew_ff; rebind_in = rebind_ff;
      lease_in = lease_ff; start_in = start_ff; agg_end_in = agg_end_ff;
      fb_in = fb_ff; started_in = started_ff;
      send = dhcl_pkg::SK_NONE; srv = 32'd0; script = dhcl_pkg::EV_NONE; hint = 1'b0;
      do_renew = 1'b0; gap = 32'd0; l7 = 35'd0; pause = 32'd0;
      margin = margin_ff;
      rvalid_in = rvalid_ff;
      if (out_ready) rvalid_in = 1'b0;
      rsp_in = rsp_ff;
      if (take) begin
         if (!started_ff) begin
            started_in = 1'b1;
            agg_end_in = now + {16'd0, csr.agg_window};
            fb_in = now;
            wanted_in = csr.req_addr;
            script = dhcl_pkg::EV_DECONFIG;
         end
         pause = now + ((now < agg_end_in) ? {16'd0, csr.agg_retry}
                                           : {16'd0, csr.norm_retry});
         case (in_work.req.action)
            dhcl_pkg::ACT_TICK: begin
               if (deadline_ff <= now) begin
                  case (phase_ff)
                     dhcl_pkg::PH_INIT: begin
                        if (listen_ff != dhcl_pkg::LS_RAW) begin
                           listen_in = dhcl_pkg::LS_RAW;
                        end else if (retry_ff < 2'(dhcl_pkg::RETRY_LIMIT)) begin
                           if (retry_ff == 2'd0) xid_in = in_work.req.fresh_xid;
                           send = dhcl_pkg::SK_DISCOVER;
                           deadline_in = now + dhcl_pkg::retry_delay(retry_ff);
                           retry_in = retry_ff + 2'd1;
                        end else begin
                           retry_in = 2'd0;
                           deadline_in = pause;
                           hint = now > fb_in;
                        end
                     end
                     dhcl_pkg::PH_REQUESTING, dhcl_pkg::PH_RENEW_REQ: begin
                        if (retry_ff < 2'(dhcl_pkg::RETRY_LIMIT)) begin
                           send = (phase_ff == dhcl_pkg::PH_RENEW_REQ)
                                  ? dhcl_pkg::SK_RENEW : dhcl_pkg::SK_SELECT;
                           srv = server_ff;
                           deadline_in = now + dhcl_pkg::retry_delay(retry_ff);
                           retry_in = retry_ff + 2'd1;
                        end else begin
                           if (phase_ff == dhcl_pkg::PH_RENEW_REQ)
                              script = dhcl_pkg::EV_DECONFIG;
                           retry_in = 2'd0;
                           phase_in = dhcl_pkg::PH_INIT;
                           deadline_in = pause;
                           listen_in = dhcl_pkg::LS_RAW;
                        end
                     end
                     dhcl_pkg::PH_BOUND, dhcl_pkg::PH_RENEWING: begin
                        if (phase_ff == dhcl_pkg::PH_BOUND) begin
                           phase_in = dhcl_pkg::PH_RENEWING;
                           listen_in = dhcl_pkg::LS_KERNEL;
                        end
                        gap = rebind_ff - renew_ff;
                        if (gap <= margin) begin
                           phase_in = dhcl_pkg::PH_REBINDING;
                           deadline_in = now + gap;
                        end else begin
                           send = dhcl_pkg::SK_RENEW;
                           srv = server_ff;
                           renew_in = {1'b0, gap[31:1]} + renew_ff;
                           deadline_in = renew_in + start_ff;
                        end
                     end
                     dhcl_pkg::PH_REBINDING: begin
                        gap = {1'b0, lease_ff} - rebind_ff;
                        if (gap <= margin) begin
                           phase_in = dhcl_pkg::PH_INIT;
                           script = dhcl_pkg::EV_DECONFIG;
                           deadline_in = now;
                           retry_in = 2'd0;
                           listen_in = dhcl_pkg::LS_RAW;
                        end else begin
                           send = dhcl_pkg::SK_REBIND;
                           rebind_in = {1'b0, gap[31:1]} + rebind_ff;
                           deadline_in = rebind_in + start_ff;
                        end
                     end
                     default: deadline_in = dhcl_pkg::RELEASED_DEADLINE;
                  endcase
               end
            end
            dhcl_pkg::ACT_MESSAGE: begin
               if (listen_ff != dhcl_pkg::LS_NONE && in_work.req.message_xid == xid_ff) begin
                  if (phase_ff == dhcl_pkg::PH_INIT) begin
                     if (in_work.req.message_type == dhcl_pkg::MT_OFFER
                         && in_work.req.sid_valid) begin
                        server_in = in_work.req.sid_value;
                        wanted_in = in_work.req.offered_address;
                        phase_in = dhcl_pkg::PH_REQUESTING;
                        deadline_in = now;
                        retry_in = 2'd0;
                     end
                  end else if (phase_ff inside {dhcl_pkg::PH_REQUESTING,
                               dhcl_pkg::PH_RENEW_REQ, dhcl_pkg::PH_RENEWING,
                               dhcl_pkg::PH_REBINDING}) begin
                     if (in_work.req.message_type == dhcl_pkg::MT_ACK) begin
                        lease_in = in_work.lease_clamped;
                        renew_in = {2'd0, lease_in[30:1]};
                        l7 = {1'b0, lease_in, 3'd0} - {4'd0, lease_in};
                        rebind_in = l7[34:3];
                        start_in = now;
                        deadline_in = renew_in + now;
                        wanted_in = in_work.req.offered_address;
                        script = (phase_ff == dhcl_pkg::PH_RENEWING
                                  || phase_ff == dhcl_pkg::PH_REBINDING)
                                 ? dhcl_pkg::EV_RENEWED : dhcl_pkg::EV_BOUND;
                        phase_in = dhcl_pkg::PH_BOUND;
                        listen_in = dhcl_pkg::LS_NONE;
                     end else if (in_work.req.message_type == dhcl_pkg::MT_NAK) begin
                        script = (phase_ff == dhcl_pkg::PH_REQUESTING)
                                 ? dhcl_pkg::EV_NAK : dhcl_pkg::EV_NAK_DECONFIG;
                        phase_in = dhcl_pkg::PH_INIT;
                        deadline_in = now;
                        wanted_in = 32'd0;
                        retry_in = 2'd0;
                        listen_in = dhcl_pkg::LS_RAW;
                     end
                  end
               end
            end
            dhcl_pkg::ACT_RENEW: do_renew = 1'b1;
            dhcl_pkg::ACT_LINK: begin
               agg_end_in = now + {16'd0, csr.agg_window};
               fb_in = now + {16'd0, csr.fallback};
               do_renew = 1'b1;
            end
            dhcl_pkg::ACT_FOREIGN: begin
               do_renew = phase_ff == dhcl_pkg::PH_BOUND
                          && in_work.req.foreign_requested_address != 32'd0
                          && in_work.req.foreign_requested_address == wanted_in;
            end
            default: ;
         endcase
         if (do_renew) begin
            case (phase_ff)
               dhcl_pkg::PH_BOUND: begin
                  listen_in = dhcl_pkg::LS_KERNEL;
                  phase_in = dhcl_pkg::PH_RENEW_REQ;
               end
               dhcl_pkg::PH_RENEWING, dhcl_pkg::PH_REBINDING:
                  phase_in = dhcl_pkg::PH_RENEW_REQ;
               dhcl_pkg::PH_RENEW_REQ: begin
                  script = dhcl_pkg::EV_DECONFIG;
                  listen_in = dhcl_pkg::LS_RAW;
                  phase_in = dhcl_pkg::PH_INIT;
               end
               dhcl_pkg::PH_REQUESTING, dhcl_pkg::PH_RELEASED: begin
                  listen_in = dhcl_pkg::LS_RAW;
                  phase_in = dhcl_pkg::PH_INIT;
               end
               default: ;
            endcase
            retry_in = 2'd0;
            deadline_in = 32'd0;
         end
         rvalid_in = 1'b1;
         rsp_in.send_kind = send;
         rsp_in.xid_out = (send != dhcl_pkg::SK_NONE) ? xid_in : 32'd0;
         rsp_in.server_out = srv;
         rsp_in.address_out = wanted_in;
         rsp_in.script_event = script;
         rsp_in.client_state = phase_in;
         rsp_in.listen_kind = listen_in;
         rsp_in.next_timeout = deadline_in;
         rsp_in.lease_out = lease_in;
         rsp_in.zeroconf_hint = hint;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dhcl_pkg::PH_INIT;
         retry_ff <= 2'd0; listen_ff <= dhcl_pkg::LS_RAW;
         xid_ff <= '0; server_ff <= '0; wanted_ff <= '0; deadline_ff <= '0;
         renew_ff <= '0; rebind_ff <= '0; lease_ff <= '0; start_ff <= '0;
         agg_end_ff <= '0; fb_ff <= '0; started_ff <= 1'b0; margin_ff <= 32'd1;
         rvalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; retry_ff <= retry_in; listen_ff <= listen_in;
         xid_ff <= xid_in; server_ff <= server_in; wanted_ff <= wanted_in;
         deadline_ff <= deadline_in; renew_ff <= renew_in; rebind_ff <= rebind_in;
         lease_ff <= lease_in; start_ff <= start_in; agg_end_ff <= agg_end_in;
         fb_ff <= fb_in; started_ff <= started_in; margin_ff <= margin_in;
         rvalid_ff <= rvalid_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule

// ===== rtl/dhcp_client_lease_fsm.sv =====
// Top level of the DHCP client lease machine: ports, registers and the two halves.
//
//  channel  direction  payload
//  req_     in         tdata: action, now_seconds, message_type, message_xid,
//                      sid_valid, sid_value, offered_address, lease_valid,
//                      lease_seconds_in, foreign_requested_address, fresh_xid
//  rsp_     out        tdata: result fields, one item per request item
//  csr_     in         write enable, register index, 32-bit data
//
// An item is held first in the front register, then in the state update register,
// and one item can be accepted every cycle while rsp_tready does not stall results.
// The lease margin is kept registered beside the lease, so no divider sits in
// the update path. Reset is synchronous; results stall only on rsp_tready.
`timescale 1ns / 1ps
module dhcp_client_lease_fsm (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action, now_seconds, message_type, message_xid, sid_valid, sid_value,
   // offered_address, lease_valid, lease_seconds_in, foreign_requested_address,
   // fresh_xid
   input  logic [239:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // send_kind, xid_out, server_out, address_out, script_event, client_state,
   // listen_kind, next_timeout, lease_out, zeroconf_hint
   output logic [175:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   dhcl_pkg::csr_type  csr_ff, csr_in;
   dhcl_pkg::work_type work;
   dhcl_pkg::rsp_type  rsp;
   logic               work_valid, work_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            dhcl_pkg::CSR_REQ_ADDR:   csr_in.req_addr = csr_data;
            dhcl_pkg::CSR_LEASE_CAP:  csr_in.lease_cap = csr_data[30:0];
            dhcl_pkg::CSR_AGG_WINDOW: csr_in.agg_window = csr_data[15:0];
            dhcl_pkg::CSR_AGG_RETRY:  csr_in.agg_retry = csr_data[15:0];
            dhcl_pkg::CSR_NORM_RETRY: csr_in.norm_retry = csr_data[15:0];
            dhcl_pkg::CSR_FALLBACK:   csr_in.fallback = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.req_addr <= 32'd0;
         csr_ff.lease_cap <= 31'd31536000;
         csr_ff.agg_window <= 16'd60;
         csr_ff.agg_retry <= 16'd3;
         csr_ff.norm_retry <= 16'd54;
         csr_ff.fallback <= 16'd120;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dhcl_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_req(dhcl_pkg::req_type'(req_tdata[dhcl_pkg::REQ_BITS-1:0])),
      .lease_cap(csr_ff.lease_cap),
      .out_valid(work_valid), .out_ready(work_ready), .out_work(work)
   );

   dhcl_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(work_valid), .in_ready(work_ready), .in_work(work),
      .csr(csr_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {{(dhcl_pkg::RSP_DATA_W - dhcl_pkg::RSP_BITS){1'b0}}, rsp};

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_lease_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(!csr_we) |-> rsp.lease_out <= csr_ff.lease_cap
      || rsp.lease_out == 31'd0 || rsp.script_event != dhcl_pkg::EV_BOUND)
      else $error("lease above cap");
   a_no_send_xid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.send_kind == dhcl_pkg::SK_NONE |-> rsp.xid_out == 32'd0)
      else $error("xid on empty send");
`endif
endmodule
